// ===== rtl/ispc_pkg.sv =====
`timescale 1ns / 1ps
package ispc_pkg;
    localparam int BufferDepthDefault = 16;
    localparam logic [6:0] SlaveAddressReset = 7'd32;
    localparam logic [15:0] TimeoutReset = 16'd200;
    localparam logic [15:0] DutyReset = 16'd194;
    localparam logic [15:0] PeriodReset = 16'd320;

    localparam logic [0:0] CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT = 1'b1;

    localparam logic [7:0] CMD_SET_DUTY = 8'h01;
    localparam logic [7:0] CMD_SET_PERIOD = 8'h02;
    localparam logic [7:0] CMD_START = 8'h03;
    localparam logic [7:0] CMD_STOP = 8'h04;
    localparam logic [7:0] CMD_STATUS = 8'h05;
    localparam logic [7:0] REPLY_OK = 8'h00;
    localparam logic [7:0] REPLY_ERROR = 8'hFF;

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_ADDRESS = 4'd1;
    localparam logic [3:0] PH_ADDR_ACK = 4'd2;
    localparam logic [3:0] PH_RECEIVE = 4'd3;
    localparam logic [3:0] PH_RX_ACK = 4'd4;
    localparam logic [3:0] PH_TRANSMIT = 4'd5;
    localparam logic [3:0] PH_TX_ACK = 4'd6;
    localparam logic [3:0] PH_IGNORE = 4'd7;
    localparam logic [3:0] PH_WRITE_FULL = 4'd8;

    // classified line sample handed from front to back
    typedef struct packed {
        logic scl;
        logic sda;
        logic rise;
        logic fall;
        logic start;
        logic stop;
    } ispc_event_t;

    // output word
    typedef struct packed {
        logic        command_done;
        logic        pwm_enable;
        logic [15:0] pwm_period;
        logic [15:0] pwm_duty;
        logic        sda_pull_low;
    } ispc_result_t;
endpackage

// ===== rtl/ispc_front.sv =====
`timescale 1ns / 1ps
// Line sampler: keeps the previous lines and classifies each sample.
module ispc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 scl_level,
    input  logic                 sda_level,
    output logic                 ev_valid,
    input  logic                 ev_ready,
    output ispc_pkg::ispc_event_t ev_data
);
    logic [1:0] prev_reg;
    logic       valid_reg;
    ispc_pkg::ispc_event_t data_reg;
    ispc_pkg::ispc_event_t ev_next;
    logic       take;

    assign in_ready = !valid_reg || ev_ready;
    assign take     = in_valid && in_ready;
    assign ev_valid = valid_reg;
    assign ev_data  = data_reg;

    // edge and bus condition detection
    always_comb
    begin
        ev_next.scl   = scl_level;
        ev_next.sda   = sda_level;
        ev_next.rise  = !prev_reg[1] && scl_level;
        ev_next.fall  = prev_reg[1] && !scl_level;
        ev_next.stop  = prev_reg[1] && scl_level && !prev_reg[0] && sda_level;
        ev_next.start = prev_reg[1] && scl_level && prev_reg[0] && !sda_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 2'b11;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                prev_reg  <= {scl_level, sda_level};
                valid_reg <= 1'b1;
            end
            else if (ev_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= ev_next;
        end
    end
endmodule

// ===== rtl/ispc_back.sv =====
`timescale 1ns / 1ps
// Bit engine, buffers and command execution; one sample per cycle while the output is not stalled.
module ispc_back
#(
    parameter int BUFFER_DEPTH = ispc_pkg::BufferDepthDefault
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ev_valid,
    output logic                  ev_ready,
    input  ispc_pkg::ispc_event_t ev_data,
    input  logic [6:0]            slave_address,
    input  logic [15:0]           timeout_ticks,
    output logic                  res_valid,
    input  logic                  res_ready,
    output ispc_pkg::ispc_result_t res_data
);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic        read_reg, read_next;
    logic [15:0] stall_reg, stall_next;
    logic [CW-1:0] rcount_reg, rcount_next;
    logic [CW-1:0] pcount_reg, pcount_next;
    logic [CW-1:0] pindex_reg, pindex_next;
    logic [15:0] duty_reg, duty_next;
    logic [15:0] period_reg, period_next;
    logic        run_reg, run_next;
    logic [7:0]  rx_mem [BUFFER_DEPTH];
    logic [7:0]  tx_mem [BUFFER_DEPTH];
    logic        rx_we;
    logic [7:0]  rx_b0, rx_b1, rx_b2;
    logic [7:0]  tx_rd;
    logic        done;
    logic        exec;
    logic        status_cmd;
    logic [7:0]  reply_byte;
    logic        pull;
    logic        out_valid_reg;
    ispc_pkg::ispc_result_t out_reg;
    logic        step;
    logic [15:0] tmo;
    logic [15:0] stall_inc;

    assign ev_ready  = !out_valid_reg || res_ready;
    assign step      = ev_valid && ev_ready;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // command fields; the first three bytes read at fixed places
    assign rx_b0 = rx_mem[0];
    assign rx_b1 = rx_mem[1];
    assign rx_b2 = rx_mem[2];
    assign tx_rd = tx_mem[pindex_reg[AW-1:0]];
    assign tmo   = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
    assign stall_inc = (stall_reg == 16'hFFFF) ? stall_reg : stall_reg + 16'd1;

    function automatic logic [7:0] reply_load(input logic [CW-1:0] idx,
                                              input logic [CW-1:0] cnt,
                                              input logic [7:0] rd);
        reply_load = (idx < cnt) ? rd : 8'hFF;
    endfunction

    // bus phase engine
    always_comb
    begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        read_next   = read_reg;
        stall_next  = stall_reg;
        rcount_next = rcount_reg;
        pcount_next = pcount_reg;
        pindex_next = pindex_reg;
        duty_next   = duty_reg;
        period_next = period_reg;
        run_next    = run_reg;
        rx_we       = 1'b0;
        done        = 1'b0;
        exec        = 1'b0;
        status_cmd  = 1'b0;
        reply_byte  = ispc_pkg::REPLY_ERROR;
        if (ev_data.stop)
        begin
            if ((phase_reg == ispc_pkg::PH_RECEIVE || phase_reg == ispc_pkg::PH_RX_ACK ||
                 phase_reg == ispc_pkg::PH_WRITE_FULL) && rcount_reg != '0)
            begin
                exec = 1'b1;
                done = 1'b1;
            end
            phase_next = ispc_pkg::PH_IDLE;
            stall_next = '0;
        end
        else if (ev_data.start)
        begin
            phase_next = ispc_pkg::PH_ADDRESS;
            bit_next   = '0;
            shift_next = '0;
            stall_next = '0;
        end
        else
        begin
            case (phase_reg)
                ispc_pkg::PH_ADDRESS, ispc_pkg::PH_RECEIVE:
                begin
                    if (ev_data.rise && bit_reg < 4'd8)
                    begin
                        shift_next = {shift_reg[6:0], ev_data.sda};
                        bit_next   = bit_reg + 4'd1;
                    end
                    else if (ev_data.fall && bit_reg >= 4'd8)
                    begin
                        if (phase_reg == ispc_pkg::PH_ADDRESS)
                        begin
                            if (shift_reg[7:1] == slave_address)
                            begin
                                read_next = shift_reg[0];
                                if (shift_reg[0])
                                    pindex_next = '0;
                                else
                                    rcount_next = '0;
                                phase_next = ispc_pkg::PH_ADDR_ACK;
                            end
                            else
                            begin
                                phase_next = ispc_pkg::PH_IGNORE;
                            end
                        end
                        else if (rcount_reg < CW'(BUFFER_DEPTH))
                        begin
                            rx_we       = 1'b1;
                            rcount_next = rcount_reg + 1'b1;
                            phase_next  = ispc_pkg::PH_RX_ACK;
                        end
                        else
                        begin
                            phase_next = ispc_pkg::PH_WRITE_FULL;
                        end
                    end
                end
                ispc_pkg::PH_ADDR_ACK, ispc_pkg::PH_RX_ACK:
                begin
                    if (ev_data.fall)
                    begin
                        bit_next = '0;
                        if (phase_reg == ispc_pkg::PH_ADDR_ACK && read_reg)
                        begin
                            shift_next = reply_load(pindex_reg, pcount_reg, tx_rd);
                            phase_next = ispc_pkg::PH_TRANSMIT;
                        end
                        else
                        begin
                            shift_next = '0;
                            phase_next = ispc_pkg::PH_RECEIVE;
                        end
                    end
                end
                ispc_pkg::PH_TRANSMIT:
                begin
                    if (ev_data.fall)
                    begin
                        bit_next = bit_reg + 4'd1;
                        if (bit_reg + 4'd1 >= 4'd8)
                            phase_next = ispc_pkg::PH_TX_ACK;
                        else
                            shift_next = {shift_reg[6:0], 1'b0};
                    end
                end
                ispc_pkg::PH_TX_ACK:
                begin
                    if (ev_data.rise && ev_data.sda)
                    begin
                        phase_next = ispc_pkg::PH_IGNORE;
                    end
                    else if (ev_data.fall)
                    begin
                        // advance and fetch next reply byte
                        bit_next   = '0;
                        phase_next = ispc_pkg::PH_TRANSMIT;
                        if (pindex_reg < pcount_reg)
                        begin
                            pindex_next = pindex_reg + 1'b1;
                            shift_next  = (pindex_reg + 1'b1 < pcount_reg)
                                          ? tx_mem[AW'(pindex_reg + 1'b1)] : 8'hFF;
                        end
                        else
                        begin
                            shift_next = 8'hFF;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // command execution at stop
        if (exec)
        begin
            case (rx_b0)
                ispc_pkg::CMD_SET_DUTY:
                begin
                    if (rcount_reg >= CW'(3))
                    begin
                        duty_next  = {rx_b1, rx_b2};
                        reply_byte = ispc_pkg::REPLY_OK;
                    end
                end
                ispc_pkg::CMD_SET_PERIOD:
                begin
                    if (rcount_reg >= CW'(3))
                    begin
                        period_next = {rx_b1, rx_b2};
                        reply_byte  = ispc_pkg::REPLY_OK;
                    end
                end
                ispc_pkg::CMD_START:
                begin
                    run_next   = 1'b1;
                    reply_byte = ispc_pkg::REPLY_OK;
                end
                ispc_pkg::CMD_STOP:
                begin
                    run_next   = 1'b0;
                    reply_byte = ispc_pkg::REPLY_OK;
                end
                ispc_pkg::CMD_STATUS:
                begin
                    status_cmd = 1'b1;
                    reply_byte = ispc_pkg::REPLY_OK;
                end
                default:
                begin
                end
            endcase
            pcount_next = status_cmd ? CW'(6) : CW'(1);
        end

        // stuck clock timeout
        if (phase_next == ispc_pkg::PH_IDLE)
        begin
            stall_next = '0;
        end
        else if (ev_data.rise || ev_data.fall)
        begin
            stall_next = '0;
        end
        else
        begin
            stall_next = stall_inc;
            if (stall_inc >= tmo)
            begin
                phase_next = ispc_pkg::PH_IDLE;
                stall_next = '0;
            end
        end

        pull = 1'b0;
        if (phase_next == ispc_pkg::PH_ADDR_ACK || phase_next == ispc_pkg::PH_RX_ACK)
            pull = 1'b1;
        else if (phase_next == ispc_pkg::PH_TRANSMIT)
            pull = !shift_next[7];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ispc_pkg::PH_IDLE;
            bit_reg       <= '0;
            shift_reg     <= '0;
            read_reg      <= 1'b0;
            stall_reg     <= '0;
            rcount_reg    <= '0;
            pcount_reg    <= '0;
            pindex_reg    <= '0;
            duty_reg      <= ispc_pkg::DutyReset;
            period_reg    <= ispc_pkg::PeriodReset;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg  <= phase_next;
                bit_reg    <= bit_next;
                shift_reg  <= shift_next;
                read_reg   <= read_next;
                stall_reg  <= stall_next;
                rcount_reg <= rcount_next;
                pcount_reg <= pcount_next;
                pindex_reg <= pindex_next;
                duty_reg   <= duty_next;
                period_reg <= period_next;
                run_reg    <= run_next;
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // buffers and output word
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (rx_we)
                rx_mem[rcount_reg[AW-1:0]] <= shift_reg;
            if (exec)
            begin
                tx_mem[0] <= reply_byte;
                if (status_cmd)
                begin
                    tx_mem[1] <= {7'd0, run_reg};
                    tx_mem[2] <= duty_reg[15:8];
                    tx_mem[3] <= duty_reg[7:0];
                    tx_mem[4] <= period_reg[15:8];
                    tx_mem[5] <= period_reg[7:0];
                end
            end
            out_reg.sda_pull_low <= pull;
            out_reg.pwm_duty     <= duty_next;
            out_reg.pwm_period   <= period_next;
            out_reg.pwm_enable   <= run_next;
            out_reg.command_done <= done;
        end
    end
endmodule

// ===== rtl/i2c_slave_pwm_command_port.sv =====
`timescale 1ns / 1ps
// I2C slave command port for a PWM unit.
// s_axis carries one sample of the bus lines per word; m_axis returns one
// word per sample with the SDA drive and the PWM settings. The cfg channel
// writes slave_address (index 0) and timeout_ticks (index 1); always ready.
// A front stage registers the sample with its edge classification, the
// back stage runs the bit engine and command execution and registers the
// output word. One sample is taken every cycle when m_axis_tready stays high.
// When the receiver stalls the output register holds, the front stage fills,
// then s_axis_tready drops. Reset returns the bus engine to idle, duty 194,
// period 320, PWM stopped, address 32 and timeout 200. Buffer contents are
// undefined until written.
module i2c_slave_pwm_command_port
#(
    parameter int BUFFER_DEPTH = ispc_pkg::BufferDepthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // scl_level, sda_level, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // sda_pull_low, pwm_duty, pwm_period,
                                       // pwm_enable, command_done, zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [6:0]  addr_reg;
    logic [15:0] tmo_reg;
    logic        ev_valid;
    logic        ev_ready;
    ispc_pkg::ispc_event_t  ev_data;
    ispc_pkg::ispc_result_t res;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ispc_pkg::SlaveAddressReset;
            tmo_reg  <= ispc_pkg::TimeoutReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ispc_pkg::CFG_SLAVE_ADDRESS: addr_reg <= cfg_data[6:0];
                ispc_pkg::CFG_TIMEOUT:       tmo_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ispc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .scl_level (s_axis_tdata[0]),
        .sda_level (s_axis_tdata[1]),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev_data   (ev_data)
    );

    ispc_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ev_valid      (ev_valid),
        .ev_ready      (ev_ready),
        .ev_data       (ev_data),
        .slave_address (addr_reg),
        .timeout_ticks (tmo_reg),
        .res_valid     (m_axis_tvalid),
        .res_ready     (m_axis_tready),
        .res_data      (res)
    );

    assign m_axis_tdata = {5'd0, res};

    // a command is never executed while SDA is being driven
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res.command_done && res.sda_pull_low))
        else $error("command done while driving SDA");
    // output word holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    // front may only stall when back is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");
endmodule
